[rtl/pcps_pkg.sv]
// Shared types, codes and constants of the poll credit packet scheduler.
`default_nettype none

package pcps_pkg;

    // Default storage sizes
    localparam int PENDING_DEPTH_DEF = 16;
    localparam int POLL_SLOTS_DEF    = 16;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int TAG_W    = 16;
    localparam int LEN_W    = 16;
    localparam int ACT_W    = 2;
    localparam int COUNT_W  = 5;
    localparam int MP_W     = 5;
    localparam int IVL_W    = 16;
    localparam int PKT_W    = TYPE_W + TAG_W + LEN_W;
    localparam int WIN_W    = IVL_W + MP_W + 1;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the registers
    localparam logic [MP_W-1:0]  MAX_POLLS_RST   = '0;
    localparam logic [IVL_W-1:0] POLL_PERIOD_RST = 16'd1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POLLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD = 2'd1;

    // Result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_SENT    = 2'd0,
        ACT_QUEUED  = 2'd1,
        ACT_DROPPED = 2'd2,
        ACT_NONE    = 2'd3
    } pcps_action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCHED,
        ST_DONE
    } pcps_state_t;

    // Command to a cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } pcps_chain_cmd_t;

endpackage

`default_nettype wire

[rtl/pcps_cell.sv]
// One storage cell of a shifting FIFO chain.
`default_nettype none

module pcps_cell #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             shift,
    input  wire logic             load,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic [WIDTH-1:0] nb_q,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;

    // Load a new entry, else take the neighbor's entry on a pop
    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= din;
        end else if (shift) begin
            q_reg <= nb_q;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[rtl/pcps_chain.sv]
// Shifting FIFO built from a row of cells; the head sits in cell 0.
`default_nettype none

module pcps_chain
    import pcps_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pcps_chain_cmd_t                cmd,
    input  wire logic [WIDTH-1:0]               din,
    output logic      [WIDTH-1:0]               head,
    output logic      [$clog2(DEPTH+1)-1:0]     fill
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic [CW-1:0]    widx;
    logic [WIDTH-1:0] q [DEPTH];

    // Write position: one lower when the chain shifts in the same cycle
    assign widx = cmd.pop ? (fill_reg - CW'(1)) : fill_reg;

    always_comb begin
        fill_next = fill_reg;
        if (cmd.push && !cmd.pop) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.pop && !cmd.push) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Row of cells, each fed by its right-hand neighbor
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] nb;
        if (i == DEPTH - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = q[i+1];
        end
        pcps_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .aclk  (aclk),
            .shift (cmd.pop),
            .load  (cmd.push && (widx == CW'(i))),
            .din   (din),
            .nb_q  (nb),
            .q     (q[i])
        );
    end

    assign head = q[0];
    assign fill = fill_reg;

    // Never pop an empty chain
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (fill_reg != '0))
        else $error("chain popped while empty");

    // Never push into a full chain without a pop
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && !cmd.pop) |-> (fill_reg != CW'(DEPTH)))
        else $error("chain pushed while full");

    // Fill stays within the depth
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("chain fill out of range");

endmodule

`default_nettype wire

[rtl/poll_credit_packet_scheduler.sv]
// Poll credit packet scheduler: one client's reply scheduling top level.
//
// Input channel s_*: one beat is a poll (s_tuser = 0) or a packet to send
// (s_tuser = 1); s_tdata carries time stamp, type, tag and length.
// Result channel m_*: exactly one beat per input beat, telling whether the
// packet was sent, queued, queued with the oldest dropped, or nothing sent,
// plus the pending and poll counts after the step.
// Config channel cfg_*: register 0 max_polls, register 1 poll period;
// write only while the block is idle. cfg_ready is always high.
// An accepted beat passes through a prepare step, then scheduling, where
// expired poll stamps are discarded one per cycle from the head of the poll
// cell chain, then a done step that hands the result to the output register.
// A poll with nothing pending skips scheduling. One item is in flight at a
// time; the next beat is accepted once the result has moved into the output
// register.
// Reset clears both queues and the counts and sets max_polls to 0 and the
// poll period to 1000. When m_tready is low the result holds in the output
// register; the block can finish one more item and then holds s_tready low.
`default_nettype none

module poll_credit_packet_scheduler
    import pcps_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int POLL_SLOTS    = POLL_SLOTS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Config write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: now_time[31:0], pkt_type[39:32], pkt_tag[55:40], pkt_length[71:56]
    input  wire logic [IN_W-1:0]       s_tdata,
    // s_tuser: mode (0 poll, 1 packet)
    input  wire logic                  s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: action[1:0], out_type[9:2], out_tag[25:10], out_length[41:26],
    //          pending_count[46:42], poll_count[51:47], zero[55:52]
    output logic      [OUT_W-1:0]      m_tdata
);

    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
    localparam int POLL_CW = $clog2(POLL_SLOTS + 1);
    localparam int CMP_W   = (POLL_CW > MP_W) ? POLL_CW : MP_W;

    pcps_state_t            state_reg, state_next;
    logic                   mode_reg, mode_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TYPE_W-1:0]      pkt_type_reg, pkt_type_next;
    logic [TAG_W-1:0]       pkt_tag_reg, pkt_tag_next;
    logic [LEN_W-1:0]       pkt_len_reg, pkt_len_next;
    logic [WIN_W-1:0]       window_reg, window_next;
    pcps_action_t           res_action_reg, res_action_next;
    logic [TAG_W-1:0]       res_tag_reg, res_tag_next;
    logic [MP_W-1:0]        max_polls_reg;
    logic [IVL_W-1:0]       poll_period_reg;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;
    logic                   out_valid_reg, out_valid_next;

    pcps_chain_cmd_t        poll_cmd, pend_cmd;
    logic [TIME_W-1:0]      poll_head;
    logic [POLL_CW-1:0]     poll_fill;
    logic [PKT_W-1:0]       pend_head;
    logic [PKT_W-1:0]       pend_din;
    logic [PEND_CW-1:0]     pend_fill;

    logic [CMP_W-1:0]       poll_cap;
    logic                   poll_drop;
    logic                   pend_full;
    logic                   stamp_fresh;
    logic [MP_W:0]          mp_plus;
    logic [TYPE_W-1:0]      res_type;
    logic [LEN_W-1:0]       res_len;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_polls_reg   <= MAX_POLLS_RST;
            poll_period_reg <= POLL_PERIOD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_POLLS:   max_polls_reg   <= cfg_data[MP_W-1:0];
                REG_POLL_PERIOD: poll_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Poll stamp chain and pending packet chain
    pcps_chain #(
        .WIDTH (TIME_W),
        .DEPTH (POLL_SLOTS)
    ) u_poll_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (poll_cmd),
        .din     (now_reg),
        .head    (poll_head),
        .fill    (poll_fill)
    );

    assign pend_din = {pkt_len_reg, pkt_tag_reg, pkt_type_reg};

    pcps_chain #(
        .WIDTH (PKT_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pend_cmd),
        .din     (pend_din),
        .head    (pend_head),
        .fill    (pend_fill)
    );

    // Poll capacity: max_polls, at least one, at most the chain depth
    always_comb begin
        if (max_polls_reg == '0) begin
            poll_cap = CMP_W'(1);
        end else if (CMP_W'(max_polls_reg) > CMP_W'(POLL_SLOTS)) begin
            poll_cap = CMP_W'(POLL_SLOTS);
        end else begin
            poll_cap = CMP_W'(max_polls_reg);
        end
    end

    assign poll_drop   = CMP_W'(poll_fill) >= poll_cap;
    assign pend_full   = pend_fill == PEND_CW'(PENDING_DEPTH);
    assign mp_plus     = {1'b0, max_polls_reg} + (MP_W+1)'(1);
    assign stamp_fresh = (now_reg - poll_head) < TIME_W'(window_reg);

    // Sent packets report their type and length, others report zero
    assign res_type = (res_action_reg == ACT_SENT) ? pkt_type_reg : '0;
    assign res_len  = (res_action_reg == ACT_SENT) ? pkt_len_reg  : '0;

    // Sequencer: next state, chain commands and result
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        now_next        = now_reg;
        pkt_type_next   = pkt_type_reg;
        pkt_tag_next    = pkt_tag_reg;
        pkt_len_next    = pkt_len_reg;
        window_next     = window_reg;
        res_action_next = res_action_reg;
        res_tag_next    = res_tag_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        poll_cmd        = '0;
        pend_cmd        = '0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next     = s_tuser;
                    now_next      = s_tdata[31:0];
                    pkt_type_next = s_tdata[39:32];
                    pkt_tag_next  = s_tdata[55:40];
                    pkt_len_next  = s_tdata[71:56];
                    state_next    = ST_PREP;
                end
            end
            ST_PREP: begin
                window_next = WIN_W'(poll_period_reg) * WIN_W'(mp_plus);
                if (!mode_reg) begin
                    // Record the poll, dropping the oldest stamp at capacity
                    poll_cmd.push = 1'b1;
                    poll_cmd.pop  = poll_drop;
                    if (pend_fill != '0) begin
                        // Release the oldest pending packet
                        pend_cmd.pop  = 1'b1;
                        pkt_type_next = pend_head[7:0];
                        pkt_tag_next  = pend_head[23:8];
                        pkt_len_next  = pend_head[39:24];
                        state_next    = ST_SCHED;
                    end else begin
                        res_action_next = ACT_NONE;
                        res_tag_next    = '0;
                        state_next      = ST_DONE;
                    end
                end else begin
                    state_next = ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (max_polls_reg == '0) begin
                    res_action_next = ACT_SENT;
                    res_tag_next    = pkt_tag_reg;
                    state_next      = ST_DONE;
                end else if (poll_fill != '0) begin
                    // Consume one stamp; a fresh one pays for the send
                    poll_cmd.pop = 1'b1;
                    if (stamp_fresh) begin
                        res_action_next = ACT_SENT;
                        res_tag_next    = pkt_tag_reg;
                        state_next      = ST_DONE;
                    end
                end else begin
                    // Queue the packet, dropping the oldest when full
                    pend_cmd.push = 1'b1;
                    if (pend_full) begin
                        pend_cmd.pop    = 1'b1;
                        res_action_next = ACT_DROPPED;
                        res_tag_next    = pend_head[23:8];
                    end else begin
                        res_action_next = ACT_QUEUED;
                        res_tag_next    = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_data_next = {4'b0, COUNT_W'(poll_fill), COUNT_W'(pend_fill),
                                     res_len, res_tag_reg, res_type, res_action_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        now_reg        <= now_next;
        pkt_type_reg   <= pkt_type_next;
        pkt_tag_reg    <= pkt_tag_next;
        pkt_len_reg    <= pkt_len_next;
        window_reg     <= window_next;
        res_action_reg <= res_action_next;
        res_tag_reg    <= res_tag_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A new result appears only after the sequencer finished an item
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && $past(out_valid_reg) && $past(m_tready)) |->
            $past(state_reg == ST_DONE))
        else $error("result loaded outside the done step");

    // In scheduling, stamps are only consumed while credit is in use
    a_scan_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCHED && poll_cmd.pop) |-> (max_polls_reg != '0))
        else $error("poll stamp consumed with direct reply");

    // An item is accepted only with no other item in flight
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted item did not start");

endmodule

`default_nettype wire

[bench/pcps_checker.sv]
// Mode codes shared by the bench, and the checker that predicts and compares scheduler results.
`timescale 1ns / 1ps

package pcps_tb_pkg;

    // Meaning of s_tuser
    localparam logic MODE_POLL = 1'b0;
    localparam logic MODE_SEND = 1'b1;

endpackage

module pcps_checker
    import pcps_pkg::*;
    import pcps_tb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_W-1:0]      m_tdata,
    output int                         fail_count,
    output int                         outstanding,
    output int                         sent_count,
    output int                         queued_count,
    output int                         dropped_count,
    output int                         idle_poll_count
);

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
    } parcel_t;

    typedef struct packed {
        pcps_action_t       action;
        logic [TYPE_W-1:0]  out_type;
        logic [TAG_W-1:0]   out_tag;
        logic [LEN_W-1:0]   out_len;
        logic [COUNT_W-1:0] pend_cnt;
        logic [COUNT_W-1:0] poll_cnt;
        logic [3:0]         pad;
    } reply_t;

    // Mirror of the block's registers and queues
    logic [MP_W-1:0]   credit_depth;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] stamp_ring [POLL_SLOTS_DEF];
    int                stamp_rd;
    int                stamp_wr;
    int                stamp_fill;
    parcel_t           parcel_ring [PENDING_DEPTH_DEF];
    int                parcel_rd;
    int                parcel_wr;
    int                parcel_fill;

    reply_t            replies_due [$];
    int                mismatches;

    function automatic logic [TIME_W-1:0] take_stamp();
        logic [TIME_W-1:0] s;
        s = stamp_ring[stamp_rd];
        stamp_rd = (stamp_rd + 1) % POLL_SLOTS_DEF;
        stamp_fill = stamp_fill - 1;
        return s;
    endfunction

    function automatic void put_stamp(logic [TIME_W-1:0] s);
        stamp_ring[stamp_wr] = s;
        stamp_wr = (stamp_wr + 1) % POLL_SLOTS_DEF;
        stamp_fill = stamp_fill + 1;
    endfunction

    function automatic parcel_t take_parcel();
        parcel_t p;
        p = parcel_ring[parcel_rd];
        parcel_rd = (parcel_rd + 1) % PENDING_DEPTH_DEF;
        parcel_fill = parcel_fill - 1;
        return p;
    endfunction

    function automatic void put_parcel(parcel_t p);
        parcel_ring[parcel_wr] = p;
        parcel_wr = (parcel_wr + 1) % PENDING_DEPTH_DEF;
        parcel_fill = parcel_fill + 1;
    endfunction

    // Send the packet directly at zero credit depth or on a fresh stamp, else queue it and drop the oldest when full
    function automatic reply_t route_parcel(parcel_t p, logic [TIME_W-1:0] stamp_now);
        reply_t            r;
        logic [TIME_W-1:0] window;
        logic [TIME_W-1:0] age;
        logic              fresh;
        parcel_t           old;
        r = '0;
        fresh = 1'b0;
        if (credit_depth == '0) begin
            fresh = 1'b1;
        end else begin
            window = TIME_W'(interval) * (TIME_W'(credit_depth) + 1);
            // Burn expired stamps, oldest first, until one is fresh
            while (!fresh && stamp_fill != 0) begin
                age = stamp_now - take_stamp();
                if (age < window) fresh = 1'b1;
            end
        end
        if (fresh) begin
            r.action = ACT_SENT;
            r.out_type = p.ptype;
            r.out_tag = p.tag;
            r.out_len = p.len;
        end else begin
            r.action = ACT_QUEUED;
            if (parcel_fill >= PENDING_DEPTH_DEF) begin
                old = take_parcel();
                r.action = ACT_DROPPED;
                r.out_tag = old.tag;
            end
            put_parcel(p);
        end
        return r;
    endfunction

    // Work out the reply to one input beat and advance the mirror state
    function automatic reply_t predict_beat(logic mode, logic [IN_W-1:0] beat);
        reply_t            r;
        parcel_t           p;
        logic [TIME_W-1:0] stamp_now;
        int                cap;
        stamp_now = beat[31:0];
        p.ptype = beat[39:32];
        p.tag = beat[55:40];
        p.len = beat[71:56];
        if (mode == MODE_POLL) begin
            cap = (credit_depth != '0) ? int'(credit_depth) : 1;
            if (cap > POLL_SLOTS_DEF) cap = POLL_SLOTS_DEF;
            if (stamp_fill >= cap && stamp_fill != 0) void'(take_stamp());
            put_stamp(stamp_now);
            if (parcel_fill != 0) begin
                r = route_parcel(take_parcel(), stamp_now);
            end else begin
                r = '0;
                r.action = ACT_NONE;
            end
        end else begin
            r = route_parcel(p, stamp_now);
        end
        r.pend_cnt = COUNT_W'(parcel_fill);
        r.poll_cnt = COUNT_W'(stamp_fill);
        return r;
    endfunction

    function automatic string show(reply_t r);
        return $sformatf("action=%s type=%02h tag=%04h len=%04h pending=%0d polls=%0d pad=%0h",
                         r.action.name(), r.out_type, r.out_tag, r.out_len,
                         r.pend_cnt, r.poll_cnt, r.pad);
    endfunction

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            credit_depth = MAX_POLLS_RST;
            interval = POLL_PERIOD_RST;
            stamp_rd = 0;
            stamp_wr = 0;
            stamp_fill = 0;
            parcel_rd = 0;
            parcel_wr = 0;
            parcel_fill = 0;
            mismatches = 0;
            replies_due.delete();
            sent_count <= 0;
            queued_count <= 0;
            dropped_count <= 0;
            idle_poll_count <= 0;
        end else begin
            // Compare a result beat with the oldest expectation
            if (m_tvalid && m_tready) begin
                got.action = pcps_action_t'(m_tdata[1:0]);
                got.out_type = m_tdata[9:2];
                got.out_tag = m_tdata[25:10];
                got.out_len = m_tdata[41:26];
                got.pend_cnt = m_tdata[46:42];
                got.poll_cnt = m_tdata[51:47];
                got.pad = m_tdata[55:52];
                if (replies_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch %0d at %0t: result with nothing expected: %s",
                                 mismatches, $realtime, show(got));
                end else begin
                    want = replies_due.pop_front();
                    if (got.action !== want.action || got.out_type !== want.out_type ||
                        got.out_tag !== want.out_tag || got.out_len !== want.out_len ||
                        got.pend_cnt !== want.pend_cnt || got.poll_cnt !== want.poll_cnt ||
                        got.pad !== want.pad) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("mismatch %0d at %0t: expected %s", mismatches, $realtime,
                                     show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_POLLS) credit_depth = cfg_data[MP_W-1:0];
                else if (cfg_index == REG_POLL_PERIOD) interval = cfg_data;
            end
            // Predict the reply to an accepted input beat
            if (s_tvalid && s_tready) begin
                want = predict_beat(s_tuser, s_tdata);
                replies_due.insert(replies_due.size(), want);
                case (want.action)
                    ACT_SENT: sent_count <= sent_count + 1;
                    ACT_QUEUED: queued_count <= queued_count + 1;
                    ACT_DROPPED: dropped_count <= dropped_count + 1;
                    default: idle_poll_count <= idle_poll_count + 1;
                endcase
            end
        end
        fail_count <= mismatches;
        outstanding <= replies_due.size();
    end

endmodule

[bench/tb_poll_credit_packet_scheduler.sv]
// Top of the scheduler bench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_poll_credit_packet_scheduler;
    import pcps_pkg::*;
    import pcps_tb_pkg::*;

    // Index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    int fail_count;
    int outstanding;
    int sent_count;
    int queued_count;
    int dropped_count;
    int idle_poll_count;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_req = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                reg_writes = 0;
    logic [TIME_W-1:0] clock_now = '0;
    logic [TIME_W-1:0] stride = 32'd1;

    poll_credit_packet_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pcps_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .sent_count      (sent_count),
        .queued_count    (queued_count),
        .dropped_count   (dropped_count),
        .idle_poll_count (idle_poll_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat after a random idle stretch; return once it is taken
    task automatic offer(input logic mode, input logic [TIME_W-1:0] stamp_now,
                         input logic [TYPE_W-1:0] ptype, input logic [TAG_W-1:0] tag,
                         input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {len, tag, ptype, stamp_now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic poll_at(input logic [TIME_W-1:0] stamp_now);
        offer(MODE_POLL, stamp_now, TYPE_W'($urandom()), TAG_W'($urandom()),
              LEN_W'($urandom()));
    endtask

    task automatic send_at(input logic [TIME_W-1:0] stamp_now, input logic [TYPE_W-1:0] ptype,
                           input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
        offer(MODE_SEND, stamp_now, ptype, tag, len);
    endtask

    // Stop offering and wait until every result is out and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // Program both registers and pick a time stride that mixes fresh and expired stamps
    task automatic configure(input int depth, input int ivl);
        set_reg(REG_MAX_POLLS, CFG_DATA_W'(depth));
        set_reg(REG_POLL_PERIOD, CFG_DATA_W'(ivl));
        stride = TIME_W'(ivl) * TIME_W'(depth + 1) / 2 + 1;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Random beats on a mostly advancing clock with occasional jumps anywhere
    task automatic run_phase(input int n, input int send_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(39) == 0) clock_now = $urandom();
            else clock_now = clock_now + $urandom_range(stride);
            offer(($urandom_range(99) < send_pct) ? MODE_SEND : MODE_POLL, clock_now,
                  TYPE_W'($urandom()), TAG_W'($urandom()), LEN_W'($urandom()));
        end
    endtask

    initial begin
        int errors;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Direct replies after reset, field extremes, polls with junk payload fields
        set_idling(0, 0);
        send_at(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_at(32'h0, 8'h00, 16'h0000, 16'h0000);
        poll_at(32'd10);
        poll_at(32'd20);
        drain();

        // Credit depth 2 (upper data bits ignored), window of 30
        set_reg(REG_MAX_POLLS, 16'hFFE2);
        set_reg(REG_POLL_PERIOD, 16'd10);
        send_at(32'd25, 8'h11, 16'h1111, 16'h0011);
        send_at(32'd26, 8'h22, 16'h2222, 16'h0022);
        poll_at(32'd100);
        poll_at(32'd300);
        poll_at(32'd310);
        // Stamp aged exactly one window counts as expired
        send_at(32'd340, 8'h33, 16'h3333, 16'h0033);
        poll_at(32'd400);
        poll_at(32'd411);
        send_at(32'd440, 8'h44, 16'h4444, 16'h0044);
        // Freshness across the time wrap
        poll_at(32'hFFFF_FFF0);
        send_at(32'h0000_000C, 8'h55, 16'h5555, 16'h0055);
        drain();

        // Zero interval: nothing is fresh, released packets go back in the queue
        set_reg(REG_POLL_PERIOD, 16'd0);
        set_reg(REG_SPARE, 16'hFFFF);
        poll_at(32'd500);
        send_at(32'd500, 8'h66, 16'h6666, 16'h0066);
        poll_at(32'd501);
        drain();

        // Fill credits deep, then lower the depth: each poll drops only one stamp
        configure(16, 65535);
        for (int i = 0; i < 5; i++) poll_at(32'd1000 + i);
        drain();
        set_reg(REG_MAX_POLLS, 16'd1);
        poll_at(32'd1005);
        send_at(32'd1006, 8'h77, 16'h7777, 16'h0077);
        drain();

        // Random phases over settings and idling patterns
        clock_now = 32'd2000;
        configure(0, 1000);
        set_idling(0, 0);
        run_phase(175, 50);
        drain();

        configure(16, 65535);
        set_idling(84, 0);
        run_phase(200, 60);
        drain();

        configure(1, 1);
        set_idling(0, 84);
        run_phase(200, 70);
        drain();

        configure($urandom_range(15, 2), $urandom_range(65535, 1));
        set_idling(9, 9);
        run_phase(200, 50);
        drain();

        // Long receiver hold-off while the sender keeps pushing
        configure(16, 1);
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        run_phase(30, 60);
        run_phase(170, 40);
        drain();

        configure($urandom_range(16, 1), $urandom_range(65535, 1));
        set_idling(0, 84);
        run_phase(200, 80);
        drain();

        errors = fail_count + outstanding;
        $display("run covered %0d beats: %0d sent, %0d queued, %0d queued with drop, %0d idle polls",
                 sent_count + queued_count + dropped_count + idle_poll_count,
                 sent_count, queued_count, dropped_count, idle_poll_count);
        $display("%0d register writes, one long receiver hold-off, %0d result mismatches",
                 reg_writes, fail_count);
        if (errors == 0) begin
            $display("tb_poll_credit_packet_scheduler: clean");
        end else begin
            $display("tb_poll_credit_packet_scheduler: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("tb_poll_credit_packet_scheduler: errors");
        $finish;
    end

endmodule
